[design/rpi_pkg.sv]
// Shared types, register indexes and helpers for the ray/plane intersection block.
package rpi_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_POINT_X  = 3'd0;
  localparam logic [2:0] REG_POINT_Y  = 3'd1;
  localparam logic [2:0] REG_POINT_Z  = 3'd2;
  localparam logic [2:0] REG_NORMAL_X = 3'd3;
  localparam logic [2:0] REG_NORMAL_Y = 3'd4;
  localparam logic [2:0] REG_NORMAL_Z = 3'd5;
  localparam logic [2:0] REG_EPSILON  = 3'd6;

  // Trace modes
  localparam logic [1:0] MODE_OCCLUSION = 2'd1;
  localparam logic [1:0] MODE_REFERENCE = 2'd2;

  localparam logic [30:0] MAX31 = 31'h7fff_ffff;
  localparam logic [62:0] MAX63 = 63'h7fff_ffff_ffff_ffff;

  // Quotient bits of t, one per divider stage
  localparam int unsigned QBITS = 31;

  // Start to result strobe, in cycles
  localparam int unsigned LATENCY = QBITS + 6;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic        [15:0] epsilon;
  } plane_cfg_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
  } ray_geo_t;

  // Negate with the most negative value clamped
  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = (v == 32'sh8000_0000) ? 32'sh7fff_ffff : -v;
    return r;
  endfunction

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sh0_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -65'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[design/ray_plane_intersection.sv]
// Top level of the ray/plane intersection block: plane registers and the datapath.
//
// Tests one ray per start pulse against a plane held in registers, in signed
// fixed point with FRAC_BITS fraction bits. A new ray may be started every
// clock cycle; the result word appears on the result ports for exactly one
// cycle, marked by result_valid_o. The distance is formed by the 31-stage
// pipelined divider, one quotient bit per stage, with the product and output
// stages around it. busy_o rises only if the queue between classifier and
// divider fills, which the divider draining a word every cycle prevents.
// Write the plane registers only while no ray is in flight.
module ray_plane_intersection import rpi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic [1:0]         trace_mode_i,
  output logic               result_valid_o,
  output logic               hit_o,
  output logic [30:0]        distance_o,
  output logic [62:0]        distance_squared_o,
  output logic signed [31:0] used_normal_x_o,
  output logic signed [31:0] used_normal_y_o,
  output logic signed [31:0] used_normal_z_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o
);

  localparam int unsigned DW = 65 - FRAC_BITS + 2;
  localparam int unsigned QW = $bits(ray_geo_t) + 1 + 2 * DW;

  // Reset values of the plane registers
  localparam plane_cfg_t CFG_RESET = '{
    point_x:  32'sd0,
    point_y:  32'sd0,
    point_z:  32'sd0,
    normal_x: 32'sd0,
    normal_y: 32'sd1 <<< FRAC_BITS,
    normal_z: 32'sd0,
    epsilon:  16'd66
  };

  // Plane registers
  plane_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_POINT_X:  cfg_q.point_x  <= cfg_data_i;
        REG_POINT_Y:  cfg_q.point_y  <= cfg_data_i;
        REG_POINT_Z:  cfg_q.point_z  <= cfg_data_i;
        REG_NORMAL_X: cfg_q.normal_x <= cfg_data_i;
        REG_NORMAL_Y: cfg_q.normal_y <= cfg_data_i;
        REG_NORMAL_Z: cfg_q.normal_z <= cfg_data_i;
        REG_EPSILON:  cfg_q.epsilon  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic     accept;
  ray_geo_t ray_in;
  logic     full;

  assign busy_o = full;
  assign accept = start_i && !busy_o;

  always_comb begin
    ray_in    = '0;
    ray_in.ox = origin_x_i;
    ray_in.oy = origin_y_i;
    ray_in.oz = origin_z_i;
    ray_in.dx = dir_x_i;
    ray_in.dy = dir_y_i;
    ray_in.dz = dir_z_i;
  end

  // Classify
  logic          f_valid, f_miss;
  ray_geo_t      f_geo;
  logic [DW-1:0] f_anum, f_aden;

  rpi_front #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .ray_i   (ray_in),
    .mode_i  (trace_mode_i),
    .cfg_i   (cfg_q),
    .valid_o (f_valid),
    .geo_o   (f_geo),
    .miss_o  (f_miss),
    .anum_o  (f_anum),
    .aden_o  (f_aden)
  );

  // Queue
  logic          q_valid;
  logic [QW-1:0] q_data;
  ray_geo_t      q_geo;
  logic          q_miss;
  logic [DW-1:0] q_anum, q_aden;

  rpi_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  ({f_geo, f_miss, f_anum, f_aden}),
    .valid_o (q_valid),
    .data_o  (q_data),
    .full_o  (full)
  );

  assign {q_geo, q_miss, q_anum, q_aden} = q_data;

  // Divide and finish
  ray_geo_t b_geo;

  rpi_back #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (q_valid),
    .geo_i              (q_geo),
    .miss_i             (q_miss),
    .anum_i             (q_anum),
    .aden_i             (q_aden),
    .eps_i              (cfg_q.epsilon),
    .valid_o            (result_valid_o),
    .hit_o              (hit_o),
    .distance_o         (distance_o),
    .distance_squared_o (distance_squared_o),
    .geo_o              (b_geo)
  );

  assign used_normal_x_o = b_geo.nx;
  assign used_normal_y_o = b_geo.ny;
  assign used_normal_z_o = b_geo.nz;
  assign point_x_o       = b_geo.ox;
  assign point_y_o       = b_geo.oy;
  assign point_z_o       = b_geo.oz;

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LATENCY) result_valid_o)
    else $error("result word missing after start");

  a_miss_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !hit_o |-> distance_o == '0 && distance_squared_o == MAX63
      && point_x_o == '0 && used_normal_y_o == '0)
    else $error("miss word not cleared");

  a_square : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && hit_o |-> distance_squared_o == 63'(distance_o) * 63'(distance_o))
    else $error("distance squared mismatch");

  a_no_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("queue filled");
`endif

endmodule

[design/rpi_front.sv]
// Front end: differences, dot products and hit/miss classification of each ray.
module rpi_front import rpi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DW        = 51
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  ray_geo_t             ray_i,
  input  logic [1:0]           mode_i,
  input  plane_cfg_t           cfg_i,
  output logic                 valid_o,
  output ray_geo_t             geo_o,
  output logic                 miss_o,
  output logic [DW-1:0]        anum_o,
  output logic [DW-1:0]        aden_o
);

  localparam int unsigned PW = 65;

  // Stage A: offsets and oriented normal
  logic                     va_q;
  logic signed [32:0]       so_x_q, so_y_q, so_z_q;
  ray_geo_t                 ga_d, ga_q;
  logic signed [31:0]       pn_x_q, pn_y_q, pn_z_q;
  logic                     ref_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  // Flip the normal in occlusion mode
  always_comb begin
    ga_d = ray_i;
    if (mode_i == MODE_OCCLUSION) begin
      ga_d.nx = neg_sat(cfg_i.normal_x);
      ga_d.ny = neg_sat(cfg_i.normal_y);
      ga_d.nz = neg_sat(cfg_i.normal_z);
    end else begin
      ga_d.nx = cfg_i.normal_x;
      ga_d.ny = cfg_i.normal_y;
      ga_d.nz = cfg_i.normal_z;
    end
  end

  always_ff @(posedge clk_i) begin
    so_x_q <= {ray_i.ox[31], ray_i.ox} - {cfg_i.point_x[31], cfg_i.point_x};
    so_y_q <= {ray_i.oy[31], ray_i.oy} - {cfg_i.point_y[31], cfg_i.point_y};
    so_z_q <= {ray_i.oz[31], ray_i.oz} - {cfg_i.point_z[31], cfg_i.point_z};
    pn_x_q <= cfg_i.normal_x;
    pn_y_q <= cfg_i.normal_y;
    pn_z_q <= cfg_i.normal_z;
    ga_q   <= ga_d;
    ref_a_q <= (mode_i == MODE_REFERENCE);
  end

  // Stage B: exact products
  logic                 vb_q;
  logic signed [PW-1:0] ps_x_q, ps_y_q, ps_z_q;
  logic signed [PW-1:0] pd_x_q, pd_y_q, pd_z_q;
  logic signed [PW-1:0] pn2_x_q, pn2_y_q, pn2_z_q;
  ray_geo_t             gb_q;
  logic                 ref_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ps_x_q  <= PW'(so_x_q) * PW'(pn_x_q);
    ps_y_q  <= PW'(so_y_q) * PW'(pn_y_q);
    ps_z_q  <= PW'(so_z_q) * PW'(pn_z_q);
    pd_x_q  <= PW'(ga_q.dx) * PW'(ga_q.nx);
    pd_y_q  <= PW'(ga_q.dy) * PW'(ga_q.ny);
    pd_z_q  <= PW'(ga_q.dz) * PW'(ga_q.nz);
    pn2_x_q <= PW'(-so_x_q) * PW'(ga_q.nx);
    pn2_y_q <= PW'(-so_y_q) * PW'(ga_q.ny);
    pn2_z_q <= PW'(-so_z_q) * PW'(ga_q.nz);
    gb_q    <= ga_q;
    ref_b_q <= ref_a_q;
  end

  // Stage C: floor, sum and classify
  logic signed [DW-1:0] side, den, num, eps_s;
  logic                 miss;

  always_comb begin
    side  = DW'(ps_x_q >>> FRAC_BITS) + DW'(ps_y_q >>> FRAC_BITS)
          + DW'(ps_z_q >>> FRAC_BITS);
    den   = DW'(pd_x_q >>> FRAC_BITS) + DW'(pd_y_q >>> FRAC_BITS)
          + DW'(pd_z_q >>> FRAC_BITS);
    num   = DW'(pn2_x_q >>> FRAC_BITS) + DW'(pn2_y_q >>> FRAC_BITS)
          + DW'(pn2_z_q >>> FRAC_BITS);
    eps_s = $signed(DW'(cfg_i.epsilon));
    miss  = ((side < eps_s) && (side > -eps_s))
         || (den == '0)
         || ((den > 0) && !ref_b_q)
         || ((num != '0) && ((num < 0) != (den < 0)));
  end

  assign valid_o = vb_q;
  assign geo_o   = gb_q;
  assign miss_o  = miss;
  assign anum_o  = (num < 0) ? DW'(-num) : DW'(num);
  assign aden_o  = (den < 0) ? DW'(-den) : DW'(den);

endmodule

[design/rpi_fifo.sv]
// Two-entry queue between the front end and the divider back end.
module rpi_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o
);

  logic [WIDTH-1:0] mem_q [0:1];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             pop, push;

  // Back end drains a word every cycle one is present
  assign pop     = (cnt_q != 2'd0);
  assign push    = push_i && ((cnt_q != 2'd2) || pop);
  assign valid_o = pop;
  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[design/rpi_back.sv]
// Back end: pipelined restoring divider for t, then t squared and the hit point.
module rpi_back import rpi_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DW        = 51
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ray_geo_t           geo_i,
  input  logic               miss_i,
  input  logic [DW-1:0]      anum_i,
  input  logic [DW-1:0]      aden_i,
  input  logic [15:0]        eps_i,
  output logic               valid_o,
  output logic               hit_o,
  output logic [30:0]        distance_o,
  output logic [62:0]        distance_squared_o,
  output ray_geo_t           geo_o
);

  localparam int unsigned RW = DW + 32;

  logic            v_q    [0:QBITS];
  logic [RW-1:0]   rem_q  [0:QBITS];
  logic [DW-1:0]   dn_q   [0:QBITS];
  logic [QBITS-1:0] q_q   [0:QBITS];
  logic            sat_q  [0:QBITS];
  logic            miss_q [0:QBITS];
  ray_geo_t        geo_q  [0:QBITS];

  // Enter the divider with the dividend scaled by the fraction bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RW'(anum_i) << FRAC_BITS;
    dn_q[0]   <= aden_i;
    q_q[0]    <= '0;
    sat_q[0]  <= (RW'(anum_i) << FRAC_BITS) >= (RW'(aden_i) << QBITS);
    miss_q[0] <= miss_i;
    geo_q[0]  <= geo_i;
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    localparam int unsigned SH = QBITS - 1 - k;
    logic [RW-1:0] cand;
    logic          ge;

    assign cand = RW'(dn_q[k]) << SH;
    assign ge   = (rem_q[k] >= cand);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= ge ? (rem_q[k] - cand) : rem_q[k];
      q_q[k+1]    <= q_q[k] | (QBITS'(ge) << SH);
      dn_q[k+1]   <= dn_q[k];
      sat_q[k+1]  <= sat_q[k];
      miss_q[k+1] <= miss_q[k];
      geo_q[k+1]  <= geo_q[k];
    end
  end

  // Saturate t, apply the minimum distance and multiply
  logic [30:0]        t;
  logic               tmiss;
  logic signed [31:0] ts;

  assign t     = sat_q[QBITS] ? MAX31 : q_q[QBITS];
  assign tmiss = miss_q[QBITS] || (t < 31'(eps_i));
  assign ts    = $signed({1'b0, t});

  logic               vm_q;
  logic               mm_q;
  logic [30:0]        tm_q;
  logic [61:0]        tt_q;
  logic signed [63:0] px_q, py_q, pz_q;
  ray_geo_t           gm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else begin
      vm_q <= v_q[QBITS];
    end
  end

  always_ff @(posedge clk_i) begin
    mm_q <= tmiss;
    tm_q <= t;
    tt_q <= 62'(t) * 62'(t);
    px_q <= 64'(ts) * 64'(geo_q[QBITS].dx);
    py_q <= 64'(ts) * 64'(geo_q[QBITS].dy);
    pz_q <= 64'(ts) * 64'(geo_q[QBITS].dz);
    gm_q <= geo_q[QBITS];
  end

  // Form the result word, zeroed on a miss, with the squared distance set to its maximum
  logic     vo_q;
  logic     hit_q;
  logic [30:0] dist_q;
  logic [62:0] dsq_q;
  ray_geo_t go_d, go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vm_q;
    end
  end

  always_comb begin
    go_d = '0;
    if (!mm_q) begin
      go_d.nx = gm_q.nx;
      go_d.ny = gm_q.ny;
      go_d.nz = gm_q.nz;
      go_d.ox = sat32(65'(gm_q.ox) + 65'(px_q >>> FRAC_BITS));
      go_d.oy = sat32(65'(gm_q.oy) + 65'(py_q >>> FRAC_BITS));
      go_d.oz = sat32(65'(gm_q.oz) + 65'(pz_q >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= !mm_q;
    dist_q <= mm_q ? '0 : tm_q;
    dsq_q  <= mm_q ? MAX63 : {1'b0, tt_q};
    go_q   <= go_d;
  end

  assign valid_o            = vo_q;
  assign hit_o              = hit_q;
  assign distance_o         = dist_q;
  assign distance_squared_o = dsq_q;
  assign geo_o              = go_q;

endmodule

[sim/tb_ray_plane_intersection.sv]
// Testbench for the ray/plane intersection block: random and directed rays checked against a predictor.
`timescale 1ns / 100ps

module tb_ray_plane_intersection;
  import rpi_pkg::*;

  localparam int unsigned FRAC   = 16;
  localparam int unsigned DRAIN  = LATENCY + 10;
  localparam int unsigned LIMIT  = 400000;
  localparam int unsigned N_RAND = 1500;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
    logic [1:0]         mode;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        tdist;
    logic [62:0]        dist_sq;
    logic signed [31:0] nx, ny, nz, px, py, pz;
  } hit_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic took = 1'b0;
  ray_t ray_q = '0;
  logic result_valid_o, hit_o;
  logic [30:0] distance_o;
  logic [62:0] distance_squared_o;
  logic signed [31:0] used_normal_x_o, used_normal_y_o, used_normal_z_o;
  logic signed [31:0] point_x_o, point_y_o, point_z_o;

  ray_plane_intersection #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start_i, .busy_o,
    .origin_x_i(ray_q.ox), .origin_y_i(ray_q.oy), .origin_z_i(ray_q.oz),
    .dir_x_i(ray_q.dx), .dir_y_i(ray_q.dy), .dir_z_i(ray_q.dz),
    .trace_mode_i(ray_q.mode), .result_valid_o, .hit_o, .distance_o,
    .distance_squared_o, .used_normal_x_o, .used_normal_y_o, .used_normal_z_o,
    .point_x_o, .point_y_o, .point_z_o
  );

  always #5 clk_i = ~clk_i;

  // Plane held by the predictor
  logic signed [63:0] pl_px, pl_py, pl_pz, pl_nx, pl_ny, pl_nz;
  logic [15:0]        pl_eps;

  ray_t ray_queue[$];
  hit_t hit_queue[$];
  int   idle_pct = 0;
  int   errors = 0;
  int   hits_seen = 0;
  int   words_seen = 0;
  longint cycles = 0;

  // Floor a product by the fraction bits
  function automatic logic signed [63:0] fshift(input logic signed [127:0] v);
    fshift = 64'(v >>> FRAC);
  endfunction

  function automatic logic signed [63:0] dot(input logic signed [63:0] ax, ay, az,
                                             input logic signed [63:0] bx, by, bz);
    dot = fshift(128'(ax) * bx) + fshift(128'(ay) * by) + fshift(128'(az) * bz);
  endfunction

  function automatic logic signed [63:0] negate_clamp(input logic signed [63:0] v);
    negate_clamp = (v == -64'sh8000_0000) ? 64'sh7fff_ffff : -v;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7fff_ffff) clamp32 = 32'sh7fff_ffff;
    else if (v < -64'sh8000_0000) clamp32 = 32'sh8000_0000;
    else clamp32 = v[31:0];
  endfunction

  function automatic hit_t trace_plane(input ray_t r);
    hit_t h;
    logic signed [63:0] nx, ny, nz, eps, side, den, num;
    logic [63:0] anum, aden, q, rem, t;
    h = '0;
    h.dist_sq = MAX63;
    nx = pl_nx; ny = pl_ny; nz = pl_nz;
    eps = 64'(pl_eps);
    side = dot(r.ox - pl_px, r.oy - pl_py, r.oz - pl_pz, nx, ny, nz);
    if (side < eps && side > -eps) return h;
    if (r.mode == MODE_OCCLUSION) begin
      nx = negate_clamp(nx); ny = negate_clamp(ny); nz = negate_clamp(nz);
    end
    den = dot(r.dx, r.dy, r.dz, nx, ny, nz);
    if (den == 0) return h;
    if (den > 0 && r.mode != MODE_REFERENCE) return h;
    num = dot(pl_px - r.ox, pl_py - r.oy, pl_pz - r.oz, nx, ny, nz);
    if (num != 0 && ((num < 0) != (den < 0))) return h;
    anum = num < 0 ? -num : num;
    aden = den < 0 ? -den : den;
    q = anum / aden;
    rem = anum % aden;
    if (q >= (64'd1 << (31 - FRAC))) t = 64'(MAX31);
    else t = (q << FRAC) + ((rem << FRAC) / aden);
    if ($signed(t) < eps) return h;
    h.hit = 1'b1;
    h.tdist = t[30:0];
    h.dist_sq = 63'(t * t);
    h.nx = nx[31:0]; h.ny = ny[31:0]; h.nz = nz[31:0];
    h.px = clamp32(r.ox + fshift(128'($signed(t)) * r.dx));
    h.py = clamp32(r.oy + fshift(128'($signed(t)) * r.dy));
    h.pz = clamp32(r.oz + fshift(128'($signed(t)) * r.dz));
    return h;
  endfunction

  // Record whether the ray word on the ports was taken at this edge
  always @(posedge clk_i) begin
    took <= start_i && !busy_o;
  end

  // Drive one ray word per accepted start, idling at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took) begin
        hit_queue.push_back(trace_plane(ray_q));
        void'(ray_queue.pop_front());
      end
      if (ray_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        ray_q <= ray_queue[0];
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Check each result word against the oldest prediction
  always @(posedge clk_i) begin
    hit_t got, exp_h;
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o) begin
      got = {hit_o, distance_o, distance_squared_o, used_normal_x_o, used_normal_y_o,
             used_normal_z_o, point_x_o, point_y_o, point_z_o};
      words_seen++;
      if (got.hit) hits_seen++;
      if (hit_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word: %p", got);
      end else begin
        exp_h = hit_queue.pop_front();
        if (got !== exp_h) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", exp_h, got);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_idle();
    while (ray_queue.size() > 0 || start_i || hit_queue.size() > 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_POINT_X:  pl_px = 64'($signed(val));
      REG_POINT_Y:  pl_py = 64'($signed(val));
      REG_POINT_Z:  pl_pz = 64'($signed(val));
      REG_NORMAL_X: pl_nx = 64'($signed(val));
      REG_NORMAL_Y: pl_ny = 64'($signed(val));
      REG_NORMAL_Z: pl_nz = 64'($signed(val));
      REG_EPSILON:  pl_eps = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_plane(input logic [31:0] px, py, pz, nx, ny, nz, input logic [15:0] e);
    write_reg(REG_POINT_X, px); write_reg(REG_POINT_Y, py); write_reg(REG_POINT_Z, pz);
    write_reg(REG_NORMAL_X, nx); write_reg(REG_NORMAL_Y, ny); write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_EPSILON, {16'd0, e});
  endtask

  // Small coordinate, mostly within ten units, sometimes full range or an extreme
  function automatic logic [31:0] coord();
    case ($urandom_range(9))
      0: coord = $urandom;
      1: coord = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: coord = 32'($signed($urandom_range(20 << FRAC)) - (10 << FRAC));
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    r.ox = coord(); r.oy = coord(); r.oz = coord();
    r.dx = coord(); r.dy = coord(); r.dz = coord();
    r.mode = 2'($urandom_range(3));
    return r;
  endfunction

  initial begin
    ray_t r;
    pl_px = 0; pl_py = 0; pl_pz = 0;
    pl_nx = 0; pl_ny = 64'sd1 << FRAC; pl_nz = 0; pl_eps = 16'd66;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset plane y=0, rays down, up, on plane, every mode
    ray_queue.push_back('{0, 32'sh0002_0000, 0, 0, -32'sh0001_0000, 0, 2'd0});
    ray_queue.push_back('{0, 32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, 2'd0});
    ray_queue.push_back('{0, 32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, MODE_REFERENCE});
    ray_queue.push_back('{0, -32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, MODE_OCCLUSION});
    ray_queue.push_back('{0, 32'sh0002_0000, 0, 0, 32'sh0001_0000, 0, MODE_OCCLUSION});
    ray_queue.push_back('{0, 32'sh0002_0000, 0, 0, -32'sh0001_0000, 0, 2'd3});
    ray_queue.push_back('{0, 32'sd10, 0, 0, -32'sh0001_0000, 0, 2'd0});
    ray_queue.push_back('{0, 32'sh0002_0000, 0, 32'sh0001_0000, 0, 0, MODE_REFERENCE});
    ray_queue.push_back('{0, 32'sh7fff_ffff, 0, 0, -32'sd1, 0, 2'd0});
    ray_queue.push_back('{32'sh8000_0000, 32'sh0001_0000, 32'sh7fff_ffff,
                          32'sh8000_0000, -32'sh0000_1000, 32'sh7fff_ffff, 2'd0});
    ray_queue.push_back('{0, 32'sh0000_0100, 0, 0, 32'sh8000_0000, 0, 2'd0});
    ray_queue.push_back('{0, 32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, MODE_REFERENCE});
    wait_idle();
    // Most negative normal components, with occlusion clamping
    set_plane(32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 16'hffff);
    ray_queue.push_back('{0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                          MODE_OCCLUSION});
    ray_queue.push_back('{0, 0, 0, -32'sh0001_0000, 0, 0, 2'd0});
    ray_queue.push_back('{0, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 0, MODE_REFERENCE});
    wait_idle();

    // Random phases over several planes, with sender idling 15, 85, then 0 percent
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_plane(0, 0, 0, 0, 32'h0001_0000, 0, 16'd0);
        1: set_plane(32'h0003_0000, 32'hfffe_0000, 32'h0001_8000, 32'h0000_b505,
                     32'h0000_b505, 0, 16'd66);
        2: set_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 16'hffff);
        3: set_plane(coord(), coord(), coord(), 32'hffff_0000, 0, 0, 16'($urandom));
        4: set_plane(32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 32'h0001_0000, 16'd1);
        default: set_plane(coord(), coord(), coord(), 32'h0000_93cd, 32'hffff_6c33,
                           32'h0000_93cd, 16'd200);
      endcase
      idle_pct = (ph < 2) ? 15 : (ph < 4) ? 85 : 0;
      for (int i = 0; i < N_RAND / 6; i++) begin
        r = rand_ray();
        // Bias toward rays that face the plane
        if ($urandom_range(2) != 0 && r.mode != MODE_OCCLUSION) begin
          r.dx = -32'(pl_nx) >>> $urandom_range(4);
          r.dy = -32'(pl_ny) >>> $urandom_range(4);
          r.dz = -32'(pl_nz) >>> $urandom_range(4);
        end
        ray_queue.push_back(r);
        // Hold off until all results are back, once per phase
        if (i == 100) while (ray_queue.size() > 0 || start_i || hit_queue.size() > 0)
          @(posedge clk_i);
      end
      wait_idle();
    end

    $display("rays checked: %0d, hits: %0d, over %0d plane settings and all modes",
             words_seen, hits_seen, 8);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
